### sv/lsm_pkg.sv
`timescale 1ns / 1ps
// lsm_pkg: shared constants and types for the line substring matcher
// no dependencies

package lsm_pkg;

  localparam int MaxPattern = 16;
  localparam int PatW       = MaxPattern * 8;
  localparam int LenW       = $clog2(MaxPattern + 1);
  localparam int IdxW       = $clog2(MaxPattern);

  localparam int CfgDataW   = 64;
  localparam int CfgIdxW    = 2;
  localparam int LineW      = 32;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPatLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPatHigh = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPatLen  = 2'd2;

  localparam logic [7:0]       LineFeed = 8'h0A;
  localparam logic [7:0]       NulByte  = 8'h00;
  localparam logic [LineW-1:0] LineMax  = {LineW{1'b1}};
  localparam logic [LineW-1:0] LineFirst = LineW'(1);

  // per-beat control broadcast to every cell
  typedef struct packed {
    logic shift;  // a line byte was accepted
    logic clear;  // a line terminator was accepted
  } lsm_ctrl_t;

endpackage

### sv/line_substring_matcher_unit.sv
`timescale 1ns / 1ps
// line_substring_matcher_unit: fixed-string line matcher, top level
// depends on lsm_pkg and lsm_cell
//
//  channel | direction | signals                                      | beat
//  in      | sink      | in_valid_i in_ready_o data_byte_i end_of_file_i | one file byte
//  out     | source    | out_valid_o out_ready_i line_number_o ...     | one line result
//  cfg     | sink      | cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i | one register write
//
// one input beat per cycle while in_ready_o is high; a chain of MaxPattern cells shifts
// the line window and each cell compares its position in the cycle the byte is accepted
// a line result is registered and shows in the cycle after its terminator beat
// in_ready_o drops only while a result is held and out_ready_i is low
// reset empties the window, restarts the counters and clears the pattern registers at once

module line_substring_matcher_unit import lsm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                end_of_file_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [LineW-1:0]    line_number_o,
  output logic                line_matched_o,
  output logic                file_end_o,
  output logic                file_had_match_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [CfgDataW-1:0] pat_low_q, pat_high_q;
  logic [4:0]          pat_len_q;
  logic [LenW-1:0]     len_used;
  logic [PatW-1:0]     pattern;

  logic [LineW-1:0] current_line_q;
  logic             line_hit_q, any_hit_q;

  logic             out_valid_q;
  logic [LineW-1:0] line_number_q;
  logic             line_matched_q, file_end_q, file_had_match_q;

  logic       in_fire, is_term, line_done, win_hit, matched_now;
  lsm_ctrl_t  ctrl;

  logic [7:0]            chain_byte  [MaxPattern];
  logic [MaxPattern-1:0] chain_valid;
  logic [MaxPattern-1:0] cell_match;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgPatLow:  pat_low_q  <= cfg_data_i;
        CfgPatHigh: pat_high_q <= cfg_data_i;
        CfgPatLen:  pat_len_q  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  assign len_used = (pat_len_q > 5'(MaxPattern)) ? LenW'(MaxPattern) : LenW'(pat_len_q);
  assign pattern  = PatW'({pat_high_q, pat_low_q});

  // handshake
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_term    = end_of_file_i || (data_byte_i == LineFeed) || (data_byte_i == NulByte);
  assign line_done  = in_fire && is_term;

  assign ctrl.shift = in_fire && !is_term;
  assign ctrl.clear = line_done;

  // cell chain: position 0 is the byte on the input
  assign chain_byte[0]  = data_byte_i;
  assign chain_valid[0] = 1'b1;

  for (genvar k = 0; k < MaxPattern; k++) begin : g_cell
    logic            need;
    logic [IdxW-1:0] sel;
    logic [7:0]      expect_byte;

    assign need        = len_used > LenW'(k);
    // newest byte lines up with the last pattern byte
    assign sel         = IdxW'(len_used - LenW'(k + 1));
    assign expect_byte = pattern[sel*8 +: 8];

    if (k < MaxPattern - 1) begin : g_mid
      lsm_cell u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctrl_i   (ctrl),
        .byte_i   (chain_byte[k]),
        .valid_i  (chain_valid[k]),
        .expect_i (expect_byte),
        .need_i   (need),
        .byte_o   (chain_byte[k+1]),
        .valid_o  (chain_valid[k+1]),
        .match_o  (cell_match[k])
      );
    end else begin : g_last
      lsm_cell u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctrl_i   (ctrl),
        .byte_i   (chain_byte[k]),
        .valid_i  (chain_valid[k]),
        .expect_i (expect_byte),
        .need_i   (need),
        .byte_o   (),
        .valid_o  (),
        .match_o  (cell_match[k])
      );
    end
  end

  assign win_hit     = (len_used != '0) && (&cell_match);
  assign matched_now = line_hit_q || (len_used == '0);

  // line and file state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      current_line_q <= LineFirst;
      line_hit_q     <= 1'b0;
      any_hit_q      <= 1'b0;
    end else if (line_done) begin
      line_hit_q <= 1'b0;
      if (end_of_file_i) begin
        current_line_q <= LineFirst;
        any_hit_q      <= 1'b0;
      end else begin
        any_hit_q <= any_hit_q || matched_now;
        if (current_line_q != LineMax) begin
          current_line_q <= current_line_q + LineFirst;
        end
      end
    end else if (ctrl.shift && win_hit) begin
      line_hit_q <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (line_done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (line_done) begin
      line_number_q    <= current_line_q;
      line_matched_q   <= matched_now;
      file_end_q       <= end_of_file_i;
      file_had_match_q <= end_of_file_i && (any_hit_q || matched_now);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign line_number_o    = line_number_q;
  assign line_matched_o   = line_matched_q;
  assign file_end_o       = file_end_q;
  assign file_had_match_o = file_had_match_q;

  a_term_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_done |=> out_valid_o)
    else $error("terminator beat gave no result");

  a_had_match_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && file_had_match_o |-> file_end_o)
    else $error("file match flag outside file end");

  a_eof_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_done && end_of_file_i |=> current_line_q == LineFirst && !any_hit_q && !line_hit_q)
    else $error("file counters not restarted");

  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    current_line_q != '0)
    else $error("line counter wrapped to zero");

  a_byte_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.shift && !out_valid_o |=> !out_valid_o)
    else $error("line byte produced a result");

endmodule

### sv/lsm_cell.sv
`timescale 1ns / 1ps
// lsm_cell: one window position of the matcher chain
// depends on lsm_pkg

module lsm_cell import lsm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lsm_ctrl_t  ctrl_i,
  input  logic [7:0] byte_i,
  input  logic       valid_i,
  input  logic [7:0] expect_i,
  input  logic       need_i,
  output logic [7:0] byte_o,
  output logic       valid_o,
  output logic       match_o
);

  logic [7:0] byte_q;
  logic       valid_q;

  // a position beyond the pattern length always agrees
  assign match_o = !need_i || (valid_i && (byte_i == expect_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o  = byte_q;
  assign valid_o = valid_q;

endmodule

### tb/sv/line_substring_matcher_checker.sv
`timescale 1ns / 1ps
// line_substring_matcher_checker: watches the in, out and cfg channels of the line matcher,
// predicts the result of every line end and compares it field by field
// depends on lsm_pkg

module line_substring_matcher_checker import lsm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [7:0]          data_byte_i,
  input  logic                end_of_file_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [LineW-1:0]    line_number_i,
  input  logic                line_matched_i,
  input  logic                file_end_i,
  input  logic                file_had_match_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  error_count_o,
  output int                  results_pending_o
);

  typedef struct packed {
    logic [LineW-1:0] line_number;
    logic             matched;
    logic             file_end;
    logic             had_match;
  } line_result_t;

  line_result_t     results_due[$];
  logic [PatW-1:0]  pattern_bits;
  logic [4:0]       pattern_len;
  logic [7:0]       history [MaxPattern-1];
  int unsigned      bytes_seen;
  logic [LineW-1:0] line_count;
  logic             line_hit;
  logic             file_hit;

  initial begin
    error_count_o = 0;
    results_pending_o = 0;
  end

  task automatic report_mismatch(input string what, input logic [LineW-1:0] got,
                                 input logic [LineW-1:0] want);
    error_count_o++;
    // keep the log short when something is badly broken
    if (error_count_o <= 40)
      $display("%0t ns line check: %s got %0h want %0h", $time, what, got, want);
  endtask

  function automatic int unsigned used_len();
    return (pattern_len > MaxPattern) ? MaxPattern : pattern_len;
  endfunction

  task automatic clear_line();
    for (int i = 0; i < MaxPattern - 1; i++) history[i] = '0;
    bytes_seen = 0;
    line_hit = 1'b0;
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic eof);
    logic [7:0]   window [MaxPattern];
    int unsigned  used;
    logic         hit;
    line_result_t res;
    used = used_len();
    if (!eof && b != LineFeed && b != NulByte) begin
      window[0] = b;
      for (int i = 1; i < MaxPattern; i++) window[i] = history[i-1];
      for (int i = MaxPattern - 2; i > 0; i--) history[i] = history[i-1];
      history[0] = b;
      if (bytes_seen < MaxPattern) bytes_seen++;
      if (used > 0 && bytes_seen >= used) begin
        hit = 1'b1;
        // oldest byte of the window lines up with pattern byte 0
        for (int i = 0; i < used; i++)
          if (window[used-1-i] != pattern_bits[8*i +: 8]) hit = 1'b0;
        if (hit) line_hit = 1'b1;
      end
    end else begin
      hit = line_hit || used == 0;
      if (hit) file_hit = 1'b1;
      res.line_number = line_count;
      res.matched     = hit;
      res.file_end    = eof;
      res.had_match   = eof && file_hit;
      results_due.push_back(res);
      clear_line();
      if (eof) begin
        line_count = LineFirst;
        file_hit = 1'b0;
      end else if (line_count != LineMax) begin
        line_count++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    line_result_t want;
    if (!rst_ni) begin
      results_due.delete();
      pattern_bits = '0;
      pattern_len = '0;
      clear_line();
      line_count = LineFirst;
      file_hit = 1'b0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (results_due.size() == 0) begin
          report_mismatch("result beat with nothing due, line", line_number_i, '0);
        end else begin
          want = results_due.pop_front();
          if (line_number_i !== want.line_number)
            report_mismatch("line_number", line_number_i, want.line_number);
          if (line_matched_i !== want.matched)
            report_mismatch("line_matched", line_matched_i, want.matched);
          if (file_end_i !== want.file_end)
            report_mismatch("file_end", file_end_i, want.file_end);
          if (file_had_match_i !== want.had_match)
            report_mismatch("file_had_match", file_had_match_i, want.had_match);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgPatLow:  pattern_bits[CfgDataW-1:0] = cfg_data_i;
          CfgPatHigh: pattern_bits[PatW-1:CfgDataW] = cfg_data_i;
          CfgPatLen:  pattern_len = cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) scan_byte(data_byte_i, end_of_file_i);
    end
    results_pending_o = results_due.size();
  end

endmodule

### tb/sv/line_substring_matcher_unit_tb.sv
`timescale 1ns / 1ps
// line_substring_matcher_unit_tb: drives files of lines and pattern writes into the matcher
// depends on lsm_pkg, line_substring_matcher_unit and line_substring_matcher_checker

module line_substring_matcher_unit_tb import lsm_pkg::*;;

  localparam logic [7:0]         LetterA    = 8'h61;
  localparam logic [7:0]         LetterB    = 8'h62;
  // index with no register behind it
  localparam logic [CfgIdxW-1:0] CfgNone    = 2'd3;
  localparam int                 CycleLimit = 300000;
  localparam int                 ItemGoal   = 1700;
  localparam int                 LongStall  = 300;

  // lines probing a two byte pattern: extremes, split by a terminator, short line,
  // a hit, and a trailing line feed
  localparam logic [7:0] AbProbe [12] = '{8'hFF, 8'h01, NulByte, LetterA, NulByte, LetterB,
                                          LetterA, LetterB, LineFeed, LetterA, LetterB, LineFeed};

  typedef enum {ReadyAll, ReadyHalf, ReadyQuarter, ReadyMost} ready_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [7:0]          data_byte_i;
  logic                end_of_file_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [LineW-1:0]    line_number_o;
  logic                line_matched_o;
  logic                file_end_o;
  logic                file_had_match_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  int              error_count;
  int              results_pending;
  int unsigned     cycles = 0;
  int unsigned     items_sent = 0;
  int unsigned     burst_left = 0;
  bit              long_stall_req = 1'b0;
  logic [PatW-1:0] pat_now = '0;
  int unsigned     pat_used = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  line_substring_matcher_unit uut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .data_byte_i, .end_of_file_i,
    .out_valid_o, .out_ready_i, .line_number_o, .line_matched_o, .file_end_o,
    .file_had_match_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  line_substring_matcher_checker u_check (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .data_byte_i, .end_of_file_i,
    .out_valid_i(out_valid_o), .out_ready_i, .line_number_i(line_number_o),
    .line_matched_i(line_matched_o), .file_end_i(file_end_o),
    .file_had_match_i(file_had_match_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .error_count_o(error_count), .results_pending_o(results_pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: stall pattern of its own, plus one long hold-off on request
  initial begin
    ready_mode_e mode;
    int unsigned left;
    out_ready_i = 1'b0;
    mode = ReadyAll;
    left = 0;
    forever begin
      @(negedge clk_i);
      if (long_stall_req) begin
        out_ready_i <= 1'b0;
        repeat (LongStall) @(negedge clk_i);
        long_stall_req = 1'b0;
        out_ready_i <= 1'b1;
      end else begin
        if (left == 0) begin
          mode = ready_mode_e'($urandom_range(0, 3));
          left = $urandom_range(16, 128);
        end
        left--;
        case (mode)
          ReadyAll:     out_ready_i <= 1'b1;
          ReadyHalf:    out_ready_i <= ($urandom_range(0, 1) == 0);
          ReadyQuarter: out_ready_i <= ($urandom_range(0, 3) == 0);
          default:      out_ready_i <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // entered and left at a falling edge, valid still high for the next beat
  task automatic send_item(input logic [7:0] b, input logic eof);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    data_byte_i   <= b;
    end_of_file_i <= eof;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [PatW-1:0] bits, input logic [4:0] len, input bit extra);
    write_reg(CfgPatLow, bits[CfgDataW-1:0]);
    write_reg(CfgPatHigh, bits[PatW-1:CfgDataW]);
    if (extra) write_reg(CfgNone, {$urandom, $urandom});
    // junk above the length field must not matter
    write_reg(CfgPatLen, ({$urandom, $urandom} & ~64'h1f) | 64'(len));
    cfg_valid_i <= 1'b0;
    pat_now = bits;
    pat_used = (len > MaxPattern) ? MaxPattern : len;
  endtask

  // stop offering and wait until every line result is out, then idle before returning
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (results_pending != 0);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic pick_pattern(input int unsigned sel);
    logic [PatW-1:0] bits;
    logic [4:0]      len;
    case (sel)
      0:       len = 5'(MaxPattern);
      1:       len = 5'($urandom_range(MaxPattern + 1, 31));
      2:       len = '0;
      default: len = 5'($urandom_range(1, 6));
    endcase
    for (int k = 0; k < MaxPattern; k++)
      bits[8*k +: 8] = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(LetterA, LetterA + 3));
    configure(bits, len, $urandom_range(0, 3) == 0);
  endtask

  // lines over a small alphabet, some with the pattern planted, some pure noise
  task automatic send_file(input int unsigned lines);
    int unsigned len;
    int unsigned at;
    logic [7:0]  b;
    bit          plant;
    bit          noisy;
    for (int l = 0; l < lines; l++) begin
      noisy = ($urandom_range(0, 9) == 0);
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12);
      plant = (pat_used > 0) && ($urandom_range(0, 2) == 0);
      if (plant && len < pat_used) len = pat_used + $urandom_range(0, 4);
      at = plant ? $urandom_range(0, len - pat_used) : 0;
      for (int k = 0; k < len; k++) begin
        if (plant && k >= at && k < at + pat_used) b = pat_now[8*(k-at) +: 8];
        else if (noisy || $urandom_range(0, 15) == 0) b = 8'($urandom_range(0, 255));
        else b = 8'($urandom_range(LetterA, LetterA + 3));
        send_item(b, 1'b0);
      end
      // a terminator after the last line gives one more, empty line
      if (l + 1 < lines || $urandom_range(0, 3) == 0)
        send_item(($urandom_range(0, 1) == 0) ? LineFeed : NulByte, 1'b0);
    end
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin
    logic [PatW-1:0] bits;
    int unsigned     phase;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    data_byte_i   = '0;
    end_of_file_i = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty pattern out of reset: every line matches, empty ones too
    send_item(LineFeed, 1'b0);
    send_item(LetterA, 1'b0);
    send_item(LineFeed, 1'b0);
    send_item(LineFeed, 1'b1);
    drain();

    bits = '0;
    bits[15:0] = {LetterB, LetterA};
    configure(bits, 5'd2, 1'b1);
    foreach (AbProbe[k]) send_item(AbProbe[k], 1'b0);
    send_item(8'h80, 1'b1);
    drain();

    // a line feed inside the pattern can never match
    bits = '0;
    bits[23:0] = {LetterB, LineFeed, LetterA};
    configure(bits, 5'd3, 1'b0);
    send_item(LetterA, 1'b0);
    send_item(LineFeed, 1'b0);
    send_item(LetterB, 1'b0);
    send_item(NulByte, 1'b1);

    phase = 0;
    while (items_sent < ItemGoal) begin
      drain();
      pick_pattern((phase < 3) ? phase : $urandom_range(0, 9));
      if (phase == 3) long_stall_req = 1'b1;
      repeat ($urandom_range(1, 3)) send_file($urandom_range(1, 6));
      // sometimes leave a line open across the next pattern write
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 10)) send_item(8'($urandom_range(LetterA, LetterA + 3)), 1'b0);
      phase++;
    end
    drain();

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
